>>> rtl/core/sha384_pkg.sv
// sha384_pkg: shared types, constants and round functions for the sha-384 engine
// no dependencies
`timescale 1ns / 1ps
package sha384_pkg;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1023:0] block;
		logic          final_blk;
	} blk_t;

	localparam logic [63:0] IV [8] = '{
		64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
		64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
		64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};

	localparam logic [63:0] RK [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

	function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction
endpackage

>>> rtl/core/sha384_front.sv
// sha384_front: packs message bytes into 1024-bit blocks and builds padding blocks
// depends on sha384_pkg
`timescale 1ns / 1ps
module sha384_front import sha384_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] message_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        blk_valid,
	input  logic        blk_ready,
	output blk_t        blk
);
	typedef enum logic [1:0] {S_GATHER, S_PAD1, S_PAD2} st_t;
	st_t           state_q;
	logic [1023:0] buf_q;
	logic [6:0]    fill_q;
	logic [127:0]  len_q;
	logic [63:0]   word_q;
	logic [3:0]    cnt_q;
	logic          last_q;
	logic [3:0]    bidx_q;
	logic          busy_q;

	logic [6:0]    pos;
	logic [1023:0] buf_next;
	logic          acc;

	function automatic logic [1023:0] pad_block(input logic [1023:0] b, input logic [6:0] f,
		input logic mark, input logic withlen);
		logic [1023:0] r;
		r = '0;
		for (int i = 0; i < 128; i++) begin
			if (mark && 7'(i) < f) r[1023-8*i -: 8] = b[1023-8*i -: 8];
			if (mark && 7'(i) == f) r[1023-8*i -: 8] = 8'h80;
		end
		if (withlen) r[127:0] = len_q;
		pad_block = r;
	endfunction

	assign full = busy_q || state_q != S_GATHER;
	assign acc  = push && !full;
	assign pos  = fill_q + 7'(bidx_q);

	// one byte per cycle into the buffer, while no full block waits for the queue
	always_comb begin
		buf_next = buf_q;
		buf_next[1023 - 8*pos -: 8] = word_q[63 - 8*bidx_q[2:0] -: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_GATHER;
			fill_q    <= '0;
			len_q     <= '0;
			busy_q    <= 1'b0;
			blk_valid <= 1'b0;
			bidx_q    <= '0;
		end else begin
			if (blk_valid && blk_ready) blk_valid <= 1'b0;
			unique case (state_q)
				S_GATHER: begin
					if (acc) begin
						word_q <= message_word;
						cnt_q  <= (byte_count > 4'd8) ? 4'd8 : byte_count;
						last_q <= last_word;
						bidx_q <= '0;
						busy_q <= 1'b1;
					end else if (busy_q && !blk_valid) begin
						if (bidx_q < cnt_q) begin
							buf_q  <= buf_next;
							bidx_q <= bidx_q + 4'd1;
							if (pos == 7'd127) begin
								blk_valid      <= 1'b1;
								blk.block      <= buf_next;
								blk.final_blk  <= 1'b0;
								fill_q         <= 7'(-(int'(bidx_q)) - 1);
							end
						end else begin
							fill_q <= pos;
							len_q  <= len_q + 128'({cnt_q, 3'b000});
							if (last_q) begin
								state_q <= S_PAD1;
							end else begin
								busy_q <= 1'b0;
							end
						end
					end
				end
				S_PAD1: if (!blk_valid) begin
					blk_valid     <= 1'b1;
					blk.block     <= pad_block(buf_q, fill_q, 1'b1, fill_q < 7'd112);
					blk.final_blk <= fill_q < 7'd112;
					state_q       <= (fill_q < 7'd112) ? S_GATHER : S_PAD2;
					if (fill_q < 7'd112) begin
						fill_q <= '0; len_q <= '0; busy_q <= 1'b0;
					end
				end
				S_PAD2: if (!blk_valid) begin
					blk_valid     <= 1'b1;
					blk.block     <= pad_block(buf_q, 7'd0, 1'b0, 1'b1);
					blk.final_blk <= 1'b1;
					state_q       <= S_GATHER;
					fill_q        <= '0; len_q <= '0; busy_q <= 1'b0;
				end
				default: state_q <= S_GATHER;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) acc |=> busy_q)
		else $error("accepted transaction not held");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_GATHER) |-> full) else $error("input open during padding");
	assert property (@(posedge clk) disable iff (!arst_n)
		(blk_valid && !blk_ready) |=> blk_valid) else $error("block dropped");
endmodule

>>> rtl/core/sha384_fifo.sv
// sha384_fifo: short block queue between front and compression core
// depends on sha384_pkg
`timescale 1ns / 1ps
module sha384_fifo import sha384_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  blk_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output blk_t out_data
);
	blk_t       mem [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready  = cnt_q != 2'(QDEPTH);
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk) if (wr) mem[wp_q] <= in_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (wr && !rd) |=> cnt_q != 0)
		else $error("queue count lost write");
	assert property (@(posedge clk) disable iff (!arst_n) (rd && !wr) |=> in_ready)
		else $error("queue count lost read");
endmodule

>>> rtl/core/sha384_core.sv
// sha384_core: 80-round compression, one round per cycle, and digest word readout
// depends on sha384_pkg
`timescale 1ns / 1ps
module sha384_core import sha384_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        blk_valid,
	output logic        blk_ready,
	input  blk_t        blk,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD, S_OUT} st_t;
	st_t         state_q;
	logic [63:0] h_q [8];
	logic [63:0] v_q [8];
	logic [63:0] w_q [16];
	logic [6:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  oidx_q;

	logic [63:0] w, t1, t2, s0, s1;

	assign blk_ready   = state_q == S_IDLE;
	assign empty       = state_q != S_OUT;
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign digest_last = oidx_q == 3'd5;

	// w_q is a shift window: w_q[0] is the word for this round
	always_comb begin
		s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
		s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
		w  = w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RK[rnd_q] + w;
		t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q   <= '0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
		end else begin
			unique case (state_q)
				S_IDLE: if (blk_valid) begin
					for (int i = 0; i < 16; i++) w_q[i] <= blk.block[1023-64*i -: 64];
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					fin_q   <= blk.final_blk;
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= S_ADD;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q  <= '0;
					state_q <= fin_q ? S_OUT : S_IDLE;
				end
				S_OUT: if (pop) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd5) begin
						for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == 7'd79) |=> state_q == S_ADD)
		else $error("round count off");
	assert property (@(posedge clk) disable iff (!arst_n) !empty |-> oidx_q <= 3'd5)
		else $error("digest index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && digest_last) |=> empty) else $error("digest not closed");
endmodule

>>> rtl/core/sha384_hash_engine.sv
// sha384_hash_engine: streaming sha-384, top level
// depends on sha384_pkg, sha384_front, sha384_fifo, sha384_core
// a word passes the byte packer one byte at a time once it is taken; each block then passes
// the one-round-per-cycle compression core, and for full words the packer sets the pace
// a last word yields one or two padding blocks, then six digest transactions
// arst_n clears all control state and loads the initial hash; no clearing pass
`timescale 1ns / 1ps
module sha384_hash_engine import sha384_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] message_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	blk_t fb, cb;
	logic fv, fr, cv, cr;

	sha384_front u_front (.clk, .arst_n, .push, .full, .message_word, .byte_count,
		.last_word, .blk_valid(fv), .blk_ready(fr), .blk(fb));
	sha384_fifo u_fifo (.clk, .arst_n, .in_valid(fv), .in_ready(fr), .in_data(fb),
		.out_valid(cv), .out_ready(cr), .out_data(cb));
	sha384_core u_core (.clk, .arst_n, .blk_valid(cv), .blk_ready(cr), .blk(cb),
		.empty, .pop, .digest_word, .word_index, .digest_last);
endmodule

>>> dv/tb_sha384_hash_engine.sv
// tb_sha384_hash_engine: self-checking testbench for the streaming sha-384 engine
// depends on sha384_pkg for the initial hash and round constants, and on sha384_hash_engine
`timescale 1ns / 1ps
module tb_sha384_hash_engine;
	import sha384_pkg::*;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        last;
	} msg_word_t;

	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  idx;
		logic        fin;
	} digest_t;

	localparam int WATCHDOG = 20000;
	localparam int HOLD_CYCLES = 600;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [63:0] message_word;
	logic [3:0]  byte_count;
	logic        last_word;
	logic        empty;
	logic        pop;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;

	msg_word_t pending_words[$];
	digest_t   digest_queue[$];

	logic [63:0] hv [8];
	logic [63:0] blk [16];
	int unsigned fill;
	logic [127:0] bitlen;

	int  errors = 0;
	int  idle_cycles = 0;
	bit  steady;
	bit  hold_req;
	int  hold_cnt;

	sha384_hash_engine u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.message_word(message_word), .byte_count(byte_count), .last_word(last_word),
		.empty(empty), .pop(pop), .digest_word(digest_word), .word_index(word_index),
		.digest_last(digest_last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [63:0] ror(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic compress_block();
		logic [63:0] v [8];
		logic [63:0] w [80];
		logic [63:0] t1, t2, s0, s1;
		for (int i = 0; i < 8; i++) v[i] = hv[i];
		for (int t = 0; t < 80; t++) begin
			if (t < 16) w[t] = blk[t];
			else begin
				s0 = ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7);
				s1 = ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6);
				w[t] = s1 + w[t-7] + s0 + w[t-16];
			end
			t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
			t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
	endtask

	task automatic append_byte(input logic [7:0] b);
		int sh;
		sh = 56 - 8 * (fill % 8);
		blk[fill / 8] = (blk[fill / 8] & ~(64'hFF << sh)) | (64'(b) << sh);
		fill++;
		if (fill == 128) begin
			compress_block();
			fill = 0;
		end
	endtask

	task automatic predict_digest(input msg_word_t m);
		int n;
		n = (m.nbytes > 8) ? 8 : int'(m.nbytes);
		for (int i = 0; i < n; i++) append_byte(m.data[63 - 8*i -: 8]);
		bitlen = bitlen + 128'(n * 8);
		if (m.last) begin
			append_byte(8'h80);
			while (fill != 112) append_byte(8'h00);
			for (int i = 0; i < 16; i++) append_byte(bitlen[127 - 8*i -: 8]);
			for (int i = 0; i < 6; i++)
				digest_queue.push_back('{word: hv[i], idx: 3'(i), fin: (i == 5)});
			for (int i = 0; i < 8; i++) hv[i] = IV[i];
			fill = 0;
			bitlen = '0;
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic add_word(input logic [63:0] d, input int nb, input bit lst);
		pending_words.push_back('{data: d, nbytes: 4'(nb), last: lst});
	endtask

	task automatic add_message(input int nwords, input int lastbytes);
		for (int i = 0; i < nwords - 1; i++) add_word(rand64(), 8, 1'b0);
		add_word(rand64(), lastbytes, 1'b1);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			message_word <= '0;
			byte_count <= '0;
			last_word <= 1'b0;
			for (int i = 0; i < 8; i++) hv[i] = IV[i];
			for (int i = 0; i < 16; i++) blk[i] = '0;
			fill = 0;
			bitlen = '0;
		end else begin
			if (push && !full) begin
				predict_digest('{data: message_word, nbytes: byte_count, last: last_word});
				void'(pending_words.pop_front());
			end
			if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 27)) begin
				push <= 1'b1;
				message_word <= pending_words[0].data;
				byte_count <= pending_words[0].nbytes;
				last_word <= pending_words[0].last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		digest_t exp_d;
		if (!arst_n) begin
			pop <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (pop && !empty) begin
				if (digest_queue.size() == 0) begin
					$error("digest transaction with none expected");
					errors++;
				end else begin
					exp_d = digest_queue.pop_front();
					if (digest_word !== exp_d.word) begin
						$error("digest_word expected %h actual %h", exp_d.word, digest_word);
						errors++;
					end
					if (word_index !== exp_d.idx) begin
						$error("word_index expected %0d actual %0d", exp_d.idx, word_index);
						errors++;
					end
					if (digest_last !== exp_d.fin) begin
						$error("digest_last expected %0d actual %0d", exp_d.fin, digest_last);
						errors++;
					end
				end
			end
			if (hold_req && hold_cnt < HOLD_CYCLES) begin
				hold_cnt <= hold_cnt + 1;
				pop <= 1'b0;
			end else begin
				pop <= steady || ($urandom_range(99) >= 27);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int k;
		steady = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, short words, counts above eight, padding edges
		add_word(64'h0, 0, 1'b1);
		add_word(64'h6162630000000000, 3, 1'b1);
		add_word(64'hFFFFFFFFFFFFFFFF, 8, 1'b1);
		add_word(64'h0000000000000000, 8, 1'b1);
		add_word(64'hFFFFFFFFFFFFFFFF, 15, 1'b1);
		add_word(64'hA5A5A5A5A5A5A5A5, 9, 1'b0);
		add_word(64'h1122334455667788, 1, 1'b0);
		add_word(64'hFFFFFFFFFFFFFFFF, 0, 1'b0);
		add_word(64'h5A5A5A5A5A5A5A5A, 7, 1'b1);
		add_message(14, 8);
		add_message(14, 0);
		add_message(15, 8);

		// receiver holds off while the sender keeps offering
		hold_req = 1'b1;
		while (pending_words.size() > 0) @(posedge clk);
		while (digest_queue.size() > 0) @(posedge clk);

		k = 0;
		while (k < 200) begin
			if ($urandom_range(9) == 0) begin
				add_word(rand64(), $urandom_range(15), $urandom_range(1));
				k++;
			end else begin
				int nw;
				nw = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(1, 16);
				add_message(nw, $urandom_range(8));
				k += nw;
			end
			if (k > 80 && k < 130) steady = 1;
			else steady = 0;
			while (pending_words.size() > 20) @(posedge clk);
		end
		add_word(rand64(), $urandom_range(8), 1'b1);
		while (pending_words.size() > 0) @(posedge clk);
		while (digest_queue.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && digest_queue.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
